@@ hw/rtl/sbcp_pkg.sv @@
package sbcp_pkg;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPRIGHT_KP    = 3'd0,
        CFG_UPRIGHT_KD    = 3'd1,
        CFG_SPEED_KP      = 3'd2,
        CFG_SPEED_KI      = 3'd3,
        CFG_STEER_KP      = 3'd4,
        CFG_STEER_KD      = 3'd5,
        CFG_BALANCE_OFS   = 3'd6,
        CFG_DRIVE_LIMIT   = 3'd7
    } cfg_idx_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic               tipped_over;
        logic               btn_right;
        logic               btn_left;
        logic               btn_backward;
        logic               btn_forward;
        logic [11:0]        range_cm;
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_x;
        logic signed [16:0] roll_angle;
        logic signed [15:0] wheel_speed_right;
        logic signed [15:0] wheel_speed_left;
    } in_item_t;

    localparam logic signed [31:0] UPRIGHT_KP_RST = -32'sd11796480;
    localparam logic signed [31:0] UPRIGHT_KD_RST = -32'sd58982;
    localparam logic signed [31:0] SPEED_KP_RST   = -32'sd52429;
    localparam logic signed [31:0] SPEED_KI_RST   = -32'sd262;
    localparam logic signed [31:0] STEER_KP_RST   = 32'sd655360;
    localparam logic signed [31:0] STEER_KD_RST   = 32'sd39322;
    localparam logic signed [16:0] BALANCE_OFS_RST = 17'sd0;
    localparam logic [15:0]        DRIVE_LIMIT_RST = 16'd7000;

    // 0.3 and 0.7 in Q16.16
    localparam logic signed [31:0] FILTER_NEW_WEIGHT = 32'sd19661;
    localparam logic signed [31:0] FILTER_OLD_WEIGHT = 32'sd45875;

    localparam logic [11:0]        NEAR_RANGE_CM = 12'd30;
    localparam logic signed [6:0]  SPEED_TGT_MAX = 7'sd10;
    localparam logic signed [9:0]  TURN_TGT_MAX  = 10'sd100;
    localparam logic signed [9:0]  TURN_STEP     = 10'sd30;
    localparam logic signed [18:0] INTEGRAL_MAX  = 19'sd20000;
    localparam logic signed [47:0] VEL_OUT_MAX   = 48'sd8388607;

endpackage

@@ hw/rtl/self_balance_cascade_pid_unit.sv @@
// Cascaded balance controller: one input item per control tick gives one item with the
// left and right motor drives. A speed PI loop (0.3/0.7 low-pass on the wheel speed error,
// integral clamped to +/-20000 and cleared on tip-over) sets the target angle of an upright
// PD loop; a steering PD loop is subtracted from / added to the upright output, and both
// drives saturate to +/-drive_limit. All products go through one registered 32x18 signed
// multiplier and one 64-bit accumulator under a step sequencer; an item passes through states
// ST_M0 to ST_T6 before its result is loaded into the output register, and only then is the
// next item taken, while the result may still wait on m_tready. A result that is still
// waiting when the next one is ready holds the sequencer.
module self_balance_cascade_pid_unit
    import sbcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // wheel_speed_left, wheel_speed_right, roll_angle, rate_x, rate_z, range_cm,
    // btn_forward, btn_backward, btn_left, btn_right, tipped_over, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_left, drive_right, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_D0, ST_I0, ST_M3, ST_M4,
        ST_D1, ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6
    } state_t;

    state_t state_reg;

    logic signed [31:0] upright_kp_reg, upright_kd_reg, speed_kp_reg, speed_ki_reg;
    logic signed [31:0] steer_kp_reg, steer_kd_reg;
    logic signed [16:0] balance_ofs_reg;
    logic [15:0]        drive_limit_reg;

    logic signed [4:0]  speed_tgt_reg, speed_tgt_next;
    logic signed [7:0]  turn_tgt_reg, turn_tgt_next;
    logic signed [17:0] filt_err_reg;
    logic signed [15:0] err_int_reg, err_int_next;

    logic signed [17:0] err_reg, err_next;
    logic signed [16:0] roll_reg;
    logic signed [15:0] rate_x_reg, rate_z_reg;
    logic               tipped_reg, turn_held_reg;

    logic signed [49:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [23:0] vel_reg;
    logic signed [33:0] diff_reg;
    logic signed [31:0] turn_reg;
    logic signed [39:0] vert_reg;
    logic signed [16:0] drive_l_reg, drive_r_reg;
    logic               m_valid_reg;

    in_item_t           item;
    logic               s_fire;

    assign item     = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-34){1'b0}}, drive_r_reg, drive_l_reg};

    // button handling for the targets of this tick
    logic signed [6:0] st_sum;
    logic signed [9:0] tt_sum;
    always_comb begin
        st_sum = (item.btn_forward || item.btn_backward) ? 7'(speed_tgt_reg) : 7'sd0;
        if (item.btn_forward) begin
            st_sum = st_sum + ((item.range_cm < NEAR_RANGE_CM) ? 7'sd1 : -7'sd1);
        end
        if (item.btn_backward) begin
            st_sum = st_sum + 7'sd1;
        end
        if (st_sum > SPEED_TGT_MAX) begin
            st_sum = SPEED_TGT_MAX;
        end else if (st_sum < -SPEED_TGT_MAX) begin
            st_sum = -SPEED_TGT_MAX;
        end
        speed_tgt_next = st_sum[4:0];

        tt_sum = (item.btn_left || item.btn_right) ? 10'(turn_tgt_reg) : 10'sd0;
        if (item.btn_left) begin
            tt_sum = tt_sum + TURN_STEP;
        end
        if (item.btn_right) begin
            tt_sum = tt_sum - TURN_STEP;
        end
        if (tt_sum > TURN_TGT_MAX) begin
            tt_sum = TURN_TGT_MAX;
        end else if (tt_sum < -TURN_TGT_MAX) begin
            tt_sum = -TURN_TGT_MAX;
        end
        turn_tgt_next = tt_sum[7:0];

        err_next = 18'(item.wheel_speed_left) + 18'(item.wheel_speed_right)
                 - 18'(speed_tgt_next);
    end

    // shared multiplier operands and accumulator shift
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic [4:0]         acc_sh;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        acc_sh = 5'd0;
        case (state_reg)
            ST_M0: begin mul_a = FILTER_NEW_WEIGHT; mul_b = err_reg; end
            ST_M1: begin mul_a = FILTER_OLD_WEIGHT; mul_b = filt_err_reg; end
            ST_I0: begin mul_a = speed_kp_reg; mul_b = filt_err_reg; end
            ST_M3: begin mul_a = speed_ki_reg; mul_b = 18'(err_int_reg); end
            ST_D1: begin mul_a = steer_kp_reg; mul_b = 18'(turn_tgt_reg); end
            ST_T0: begin
                mul_a = turn_held_reg ? 32'sd0 : steer_kd_reg;
                mul_b = 18'(rate_z_reg);
            end
            ST_T1: begin mul_a = upright_kp_reg; mul_b = $signed({1'b0, diff_reg[16:0]}); end
            ST_T2: begin mul_a = upright_kp_reg; mul_b = 18'($signed(diff_reg[33:17])); end
            ST_T3: begin mul_a = upright_kd_reg; mul_b = 18'(rate_x_reg); acc_sh = 5'd17; end
            ST_T4: acc_sh = 5'd8;
            default: ;
        endcase
    end

    logic signed [63:0] prod_ext, acc_add;
    assign prod_ext = 64'(prod_reg);
    assign acc_add  = acc_reg + (prod_ext <<< acc_sh);

    // truncation toward zero of acc / 2^16 and acc / 2^24
    logic signed [47:0] acc_q16;
    logic signed [39:0] acc_q24;
    assign acc_q16 = acc_reg[63:16] + {47'd0, acc_reg[63] && (|acc_reg[15:0])};
    assign acc_q24 = acc_reg[63:24] + {39'd0, acc_reg[63] && (|acc_reg[23:0])};

    logic signed [23:0] vel_next;
    always_comb begin
        if (acc_q16 > VEL_OUT_MAX) begin
            vel_next = VEL_OUT_MAX[23:0];
        end else if (acc_q16 < -VEL_OUT_MAX) begin
            vel_next = 24'(-VEL_OUT_MAX);
        end else begin
            vel_next = acc_q16[23:0];
        end
    end

    logic signed [18:0] int_sum;
    always_comb begin
        int_sum = 19'(err_int_reg) + 19'(filt_err_reg);
        if (int_sum > INTEGRAL_MAX) begin
            int_sum = INTEGRAL_MAX;
        end else if (int_sum < -INTEGRAL_MAX) begin
            int_sum = -INTEGRAL_MAX;
        end
        err_int_next = tipped_reg ? 16'sd0 : int_sum[15:0];
    end

    logic signed [33:0] diff_next;
    assign diff_next = 34'(roll_reg) - 34'($signed({vel_reg, 8'd0})) - 34'(balance_ofs_reg);

    logic signed [40:0] lim, sum_l, sum_r;
    logic signed [16:0] drive_l_next, drive_r_next;
    assign lim   = $signed({25'd0, drive_limit_reg});
    assign sum_l = 41'(vert_reg) - 41'(turn_reg);
    assign sum_r = 41'(vert_reg) + 41'(turn_reg);
    always_comb begin
        if (sum_l > lim) begin
            drive_l_next = lim[16:0];
        end else if (sum_l < -lim) begin
            drive_l_next = 17'(-lim);
        end else begin
            drive_l_next = sum_l[16:0];
        end
        if (sum_r > lim) begin
            drive_r_next = lim[16:0];
        end else if (sum_r < -lim) begin
            drive_r_next = 17'(-lim);
        end else begin
            drive_r_next = sum_r[16:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upright_kp_reg  <= UPRIGHT_KP_RST;
            upright_kd_reg  <= UPRIGHT_KD_RST;
            speed_kp_reg    <= SPEED_KP_RST;
            speed_ki_reg    <= SPEED_KI_RST;
            steer_kp_reg    <= STEER_KP_RST;
            steer_kd_reg    <= STEER_KD_RST;
            balance_ofs_reg <= BALANCE_OFS_RST;
            drive_limit_reg <= DRIVE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_UPRIGHT_KP:  upright_kp_reg  <= $signed(cfg_wdata);
                CFG_UPRIGHT_KD:  upright_kd_reg  <= $signed(cfg_wdata);
                CFG_SPEED_KP:    speed_kp_reg    <= $signed(cfg_wdata);
                CFG_SPEED_KI:    speed_ki_reg    <= $signed(cfg_wdata);
                CFG_STEER_KP:    steer_kp_reg    <= $signed(cfg_wdata);
                CFG_STEER_KD:    steer_kd_reg    <= $signed(cfg_wdata);
                CFG_BALANCE_OFS: balance_ofs_reg <= $signed(cfg_wdata[16:0]);
                CFG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            speed_tgt_reg <= '0;
            turn_tgt_reg  <= '0;
            filt_err_reg  <= '0;
            err_int_reg   <= '0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_T6) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        speed_tgt_reg <= speed_tgt_next;
                        turn_tgt_reg  <= turn_tgt_next;
                        err_reg       <= err_next;
                        roll_reg      <= item.roll_angle;
                        rate_x_reg    <= item.rate_x;
                        rate_z_reg    <= item.rate_z;
                        tipped_reg    <= item.tipped_over;
                        turn_held_reg <= item.btn_left || item.btn_right;
                        state_reg     <= ST_M0;
                    end
                end
                ST_M0: state_reg <= ST_M1;
                ST_M1: begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    acc_reg   <= acc_add;
                    state_reg <= ST_D0;
                end
                ST_D0: begin
                    filt_err_reg <= acc_q16[17:0];
                    state_reg    <= ST_I0;
                end
                ST_I0: begin
                    err_int_reg <= err_int_next;
                    state_reg   <= ST_M3;
                end
                ST_M3: begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_M4;
                end
                ST_M4: begin
                    acc_reg   <= acc_add;
                    state_reg <= ST_D1;
                end
                ST_D1: begin
                    vel_reg   <= vel_next;
                    state_reg <= ST_T0;
                end
                ST_T0: begin
                    acc_reg   <= prod_ext;
                    diff_reg  <= diff_next;
                    state_reg <= ST_T1;
                end
                ST_T1: begin
                    acc_reg   <= acc_add;
                    state_reg <= ST_T2;
                end
                ST_T2: begin
                    // steering sum done; start the upright sum on the low angle half
                    turn_reg  <= acc_q16[31:0];
                    acc_reg   <= prod_ext;
                    state_reg <= ST_T3;
                end
                ST_T3: begin
                    acc_reg   <= acc_add;
                    state_reg <= ST_T4;
                end
                ST_T4: begin
                    acc_reg   <= acc_add;
                    state_reg <= ST_T5;
                end
                ST_T5: begin
                    vert_reg  <= acc_q24;
                    state_reg <= ST_T6;
                end
                ST_T6: begin
                    if (!m_valid_reg || m_tready) begin
                        drive_l_reg <= drive_l_next;
                        drive_r_reg <= drive_r_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/sbcp_checker.sv @@
module sbcp_checker
    import sbcp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // busy with the item just taken
    a_busy_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an item");

    a_busy_later: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##8 !s_tready)
        else $error("input ready before the item finished");

    // item fields stay defined while offered
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("input item has unknown bits");

endmodule

bind self_balance_cascade_pid_unit sbcp_checker u_sbcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
